// ----- src/column_rle_sprite_decoder_unit_assert.svh -----
// Assertion macros for the column RLE sprite decoder.
`ifndef COLUMN_RLE_SPRITE_DECODER_UNIT_ASSERT_SVH
`define COLUMN_RLE_SPRITE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define CRSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crsd assertion failed");
`define CRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crsd assertion failed");
`else
`define CRSD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CRSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/crsd_pkg.sv -----
// Types and constants shared by the column RLE sprite decoder.
package crsd_pkg;

	typedef enum logic [2:0] {
		PH_TOP     = 3'd0,
		PH_BOTTOM  = 3'd1,
		PH_LEFT    = 3'd2,
		PH_RIGHT   = 3'd3,
		PH_CONTROL = 3'd4,
		PH_LITERAL = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_STEP = 2'd1,
		ST_EMIT = 2'd2
	} state_t;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_RUN   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [8:0] X_LIMIT     = 9'd511;
	localparam logic [7:0] LITERAL_BIT = 8'h80;
	localparam logic [7:0] COUNT_MASK  = 8'h7f;

	typedef struct packed {
		logic [8:0] x;
		logic [8:0] y;
	} pos_t;

	typedef struct packed {
		logic [7:0] top;
		logic [7:0] bottom;
		logic [7:0] width;
		logic [7:0] height;
	} bounds_t;

endpackage

// ----- src/crsd_stepper.sv -----
// Position stepper: one column-major advance and the in-frame test.
module crsd_stepper (
	input  crsd_pkg::pos_t    cur,
	input  crsd_pkg::bounds_t bounds,
	output crsd_pkg::pos_t    nxt,
	output logic              in_frame
);

	logic [9:0] y_inc;

	assign y_inc = {1'b0, cur.y} + 10'd1;

	always_comb begin
		if (y_inc >= {2'b00, bounds.bottom}) begin
			nxt.y = {1'b0, bounds.top};
			nxt.x = (cur.x < crsd_pkg::X_LIMIT) ? cur.x + 9'd1 : cur.x;
		end else begin
			nxt.y = y_inc[8:0];
			nxt.x = cur.x;
		end
	end

	assign in_frame = (cur.x < {1'b0, bounds.width}) && (cur.y < {1'b0, bounds.height});

endmodule

// ----- src/column_rle_sprite_decoder_unit.sv -----
// Column RLE sprite decoder top level.
// Decodes one encoded frame byte per input transaction: a four-byte header
// (top, bottom, left, right), then control bytes announcing literal palette
// bytes or transparent runs, with positions walked column-major. A header byte,
// a control byte or a zero run is taken while the decoder stays idle; a literal
// byte or a nonzero transparent run moves it into the step state, where a single
// position stepper walks the run one pixel per cycle with the input held off. When
// the output register is still occupied and the receiver stalls at the final step,
// the decoder waits in the emit state for as long as the receiver keeps stalling.
// Out-of-frame positions give an error result instead of stopping the frame.
// Configuration writes are taken every cycle and must only be issued while the decoder is idle.
module column_rle_sprite_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] pos_x, [15:8] pos_y, [23:16] color_index,
	                                    // [30:24] run_length, [31] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	`include "column_rle_sprite_decoder_unit_assert.svh"

	crsd_pkg::state_t  state_q, state_d;
	crsd_pkg::phase_t  phase_q;
	crsd_pkg::pos_t    pos_q, start_q, step_nxt;
	crsd_pkg::bounds_t bounds;
	crsd_pkg::kind_t   kind_now;
	logic [7:0] frame_width_q, frame_height_q, box_top_q, box_bottom_q;
	logic [6:0] lit_left_q, cnt_q, len_q;
	logic [7:0] color_q;
	logic       ok_q, is_run_q, done_q, step_in_frame;
	logic       in_acc, start_step, ctrl_phase, fin_step, out_free, load_out, ok_now;
	logic       out_valid_q, out_done_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_x_q, out_y_q, out_color_q;
	logic [6:0] out_len_q;

	assign bounds = '{top: box_top_q, bottom: box_bottom_q,
		width: frame_width_q, height: frame_height_q};

	crsd_stepper u_stepper (
		.cur      (pos_q),
		.bounds   (bounds),
		.nxt      (step_nxt),
		.in_frame (step_in_frame)
	);

	assign in_acc     = s_axis_tvalid && s_axis_tready;
	assign ctrl_phase = (phase_q != crsd_pkg::PH_TOP) && (phase_q != crsd_pkg::PH_BOTTOM)
		&& (phase_q != crsd_pkg::PH_LEFT) && (phase_q != crsd_pkg::PH_RIGHT)
		&& (phase_q != crsd_pkg::PH_LITERAL);
	assign start_step = in_acc && ((phase_q == crsd_pkg::PH_LITERAL) ||
		(ctrl_phase && ((s_axis_tdata & crsd_pkg::LITERAL_BIT) == 8'd0)
		&& (s_axis_tdata != 8'd0)));
	assign out_free   = !out_valid_q || m_axis_tready;
	assign fin_step   = (state_q == crsd_pkg::ST_STEP) && (cnt_q == 7'd1);
	assign ok_now     = (state_q == crsd_pkg::ST_STEP) ? (ok_q && step_in_frame) : ok_q;
	assign kind_now   = !ok_now ? crsd_pkg::KIND_ERROR :
		(is_run_q ? crsd_pkg::KIND_RUN : crsd_pkg::KIND_PIXEL);

	always_comb begin
		state_d = state_q;
		case (state_q)
			crsd_pkg::ST_IDLE: begin
				if (start_step) state_d = crsd_pkg::ST_STEP;
			end
			crsd_pkg::ST_STEP: begin
				if (cnt_q == 7'd1) state_d = out_free ? crsd_pkg::ST_IDLE : crsd_pkg::ST_EMIT;
			end
			crsd_pkg::ST_EMIT: begin
				if (out_free) state_d = crsd_pkg::ST_IDLE;
			end
			default: state_d = crsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			crsd_pkg::ST_IDLE: s_axis_tready = 1'b1;
			crsd_pkg::ST_STEP: load_out = fin_step && out_free;
			crsd_pkg::ST_EMIT: load_out = out_free;
			default: begin
				s_axis_tready = 1'b0;
				load_out      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= crsd_pkg::ST_IDLE;
			phase_q        <= crsd_pkg::PH_TOP;
			frame_width_q  <= 8'd160;
			frame_height_q <= 8'd120;
			box_top_q      <= 8'd0;
			box_bottom_q   <= 8'd0;
			pos_q          <= '0;
			lit_left_q     <= 7'd0;
			cnt_q          <= 7'd0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					crsd_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
					crsd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				case (phase_q)
					crsd_pkg::PH_TOP: begin
						box_top_q <= s_axis_tdata;
						pos_q.y   <= {1'b0, s_axis_tdata};
						phase_q   <= crsd_pkg::PH_BOTTOM;
					end
					crsd_pkg::PH_BOTTOM: begin
						box_bottom_q <= s_axis_tdata;
						phase_q      <= crsd_pkg::PH_LEFT;
					end
					crsd_pkg::PH_LEFT: begin
						pos_q.x <= {1'b0, s_axis_tdata};
						phase_q <= crsd_pkg::PH_RIGHT;
					end
					crsd_pkg::PH_RIGHT: phase_q <= crsd_pkg::PH_CONTROL;
					crsd_pkg::PH_LITERAL: begin
						lit_left_q <= lit_left_q - 7'd1;
						if (lit_left_q == 7'd1) phase_q <= crsd_pkg::PH_CONTROL;
					end
					default: begin
						phase_q <= crsd_pkg::PH_CONTROL;
						if ((s_axis_tdata & crsd_pkg::LITERAL_BIT) != 8'd0) begin
							lit_left_q <= s_axis_tdata[6:0];
							if ((s_axis_tdata & crsd_pkg::COUNT_MASK) != 8'd0)
								phase_q <= crsd_pkg::PH_LITERAL;
						end
					end
				endcase
				if (s_axis_tlast) begin
					phase_q    <= crsd_pkg::PH_TOP;
					lit_left_q <= 7'd0;
				end
			end else if (state_q == crsd_pkg::ST_STEP) begin
				pos_q <= step_nxt;
			end
			if (start_step) begin
				cnt_q <= (phase_q == crsd_pkg::PH_LITERAL) ? 7'd1 : s_axis_tdata[6:0];
			end else if (state_q == crsd_pkg::ST_STEP) begin
				cnt_q <= cnt_q - 7'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_step) begin
			start_q  <= pos_q;
			ok_q     <= 1'b1;
			done_q   <= s_axis_tlast;
			is_run_q <= (phase_q != crsd_pkg::PH_LITERAL);
			color_q  <= (phase_q == crsd_pkg::PH_LITERAL) ? s_axis_tdata : 8'd0;
			len_q    <= (phase_q == crsd_pkg::PH_LITERAL) ? 7'd1 : s_axis_tdata[6:0];
		end else if (state_q == crsd_pkg::ST_STEP) begin
			ok_q <= ok_q && step_in_frame;
		end
		if (load_out) begin
			out_kind_q  <= kind_now;
			out_x_q     <= start_q.x[8] ? 8'hff : start_q.x[7:0];
			out_y_q     <= start_q.y[8] ? 8'hff : start_q.y[7:0];
			out_color_q <= color_q;
			out_len_q   <= len_q;
			out_done_q  <= done_q;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_len_q, out_color_q, out_y_q, out_x_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_done_q;

	`CRSD_ASSERT_SAME(a_step_count, clk, arst_n, state_q == crsd_pkg::ST_STEP, cnt_q != 7'd0)
	`CRSD_ASSERT_SAME(a_literal_left, clk, arst_n, phase_q == crsd_pkg::PH_LITERAL, lit_left_q != 7'd0)
	`CRSD_ASSERT_NEXT(a_start_step, clk, arst_n, start_step, state_q == crsd_pkg::ST_STEP && !s_axis_tready)

endmodule

// ----- test/crsd_decode_check.sv -----
// Channel monitor that predicts decoder results and compares them with the output stream.
module crsd_decode_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [7:0]  s_data,
	input  logic        s_last,
	input  logic        m_valid,
	input  logic        m_ready,
	input  logic [31:0] m_data,
	input  logic [1:0]  m_user,
	input  logic        m_last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		crsd_pkg::kind_t kind;
		logic [7:0]      x;
		logic [7:0]      y;
		logic [7:0]      color;
		logic [6:0]      len;
		logic            done;
	} sprite_result_t;

	sprite_result_t pix_expect[$];

	crsd_pkg::phase_t pf_phase;
	logic [7:0] pf_top;
	logic [7:0] pf_bottom;
	logic [8:0] pf_x;
	logic [8:0] pf_y;
	logic [6:0] pf_lits;
	logic [7:0] pf_width;
	logic [7:0] pf_height;
	int         fails;

	function automatic logic [7:0] sat8(input logic [8:0] v);
		return (v > 9'd255) ? 8'hff : v[7:0];
	endfunction

	function automatic logic in_frame();
		return (pf_x < {1'b0, pf_width}) && (pf_y < {1'b0, pf_height});
	endfunction

	function automatic void step_pos();
		logic [9:0] ny;
		ny = {1'b0, pf_y} + 10'd1;
		if (ny >= {2'b00, pf_bottom}) begin
			ny = {2'b00, pf_top};
			if (pf_x < crsd_pkg::X_LIMIT)
				pf_x = pf_x + 9'd1;
		end
		pf_y = ny[8:0];
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic l);
		sprite_result_t r;
		logic           hit;
		logic           ok;
		logic [8:0]     x0;
		logic [8:0]     y0;
		int             m;
		r = '0;
		hit = 1'b0;
		ok = 1'b1;
		case (pf_phase)
		crsd_pkg::PH_TOP: begin
			pf_top = b;
			pf_y = {1'b0, b};
			pf_phase = crsd_pkg::PH_BOTTOM;
		end
		crsd_pkg::PH_BOTTOM: begin
			pf_bottom = b;
			pf_phase = crsd_pkg::PH_LEFT;
		end
		crsd_pkg::PH_LEFT: begin
			pf_x = {1'b0, b};
			pf_phase = crsd_pkg::PH_RIGHT;
		end
		crsd_pkg::PH_RIGHT: begin
			pf_phase = crsd_pkg::PH_CONTROL;
		end
		crsd_pkg::PH_LITERAL: begin
			ok = in_frame();
			r.kind = ok ? crsd_pkg::KIND_PIXEL : crsd_pkg::KIND_ERROR;
			r.x = sat8(pf_x);
			r.y = sat8(pf_y);
			r.color = b;
			r.len = 7'd1;
			r.done = l;
			hit = 1'b1;
			step_pos();
			pf_lits = pf_lits - 7'd1;
			if (pf_lits == 7'd0)
				pf_phase = crsd_pkg::PH_CONTROL;
		end
		default: begin
			pf_phase = crsd_pkg::PH_CONTROL;
			if ((b & crsd_pkg::LITERAL_BIT) != 8'h00) begin
				pf_lits = b[6:0];
				if (pf_lits != 7'd0)
					pf_phase = crsd_pkg::PH_LITERAL;
			end else if (b != 8'h00) begin
				x0 = pf_x;
				y0 = pf_y;
				for (m = 0; m < b; m++) begin
					if (!in_frame())
						ok = 1'b0;
					step_pos();
				end
				r.kind = ok ? crsd_pkg::KIND_RUN : crsd_pkg::KIND_ERROR;
				r.x = sat8(x0);
				r.y = sat8(y0);
				r.color = 8'h00;
				r.len = b[6:0];
				r.done = l;
				hit = 1'b1;
			end
		end
		endcase
		if (l) begin
			pf_phase = crsd_pkg::PH_TOP;
			pf_lits = 7'd0;
		end
		if (hit)
			pix_expect.push_back(r);
	endtask

	task automatic note_fail(input string what, input sprite_result_t e, input sprite_result_t g);
		fails++;
		if (fails <= 10)
			$display("%s: exp kind=%0d x=%0d y=%0d color=%0d len=%0d done=%0d, %s",
				what, e.kind, e.x, e.y, e.color, e.len, e.done,
				$sformatf("got kind=%0d x=%0d y=%0d color=%0d len=%0d done=%0d",
				g.kind, g.x, g.y, g.color, g.len, g.done));
	endtask

	task automatic check_result();
		sprite_result_t got;
		sprite_result_t e;
		got.kind = crsd_pkg::kind_t'(m_user);
		got.x = m_data[7:0];
		got.y = m_data[15:8];
		got.color = m_data[23:16];
		got.len = m_data[30:24];
		got.done = m_last;
		if (pix_expect.size() == 0) begin
			note_fail("unexpected result", '0, got);
		end else begin
			e = pix_expect.pop_front();
			if (got.kind !== e.kind || got.x !== e.x || got.y !== e.y ||
			    got.color !== e.color || got.len !== e.len || got.done !== e.done)
				note_fail("mismatch", e, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_width = 8'd160;
			pf_height = 8'd120;
			pf_phase = crsd_pkg::PH_TOP;
			pf_top = 8'd0;
			pf_bottom = 8'd0;
			pf_x = 9'd0;
			pf_y = 9'd0;
			pf_lits = 7'd0;
			pix_expect.delete();
			fails = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == crsd_pkg::REG_FRAME_WIDTH)
					pf_width = cfg_data;
				else if (cfg_index == crsd_pkg::REG_FRAME_HEIGHT)
					pf_height = cfg_data;
			end
			if (s_valid && s_ready)
				decode_byte(s_data, s_last);
			if (m_valid && m_ready)
				check_result();
			mismatches <= fails;
			pending <= pix_expect.size();
		end
	end

endmodule

// ----- test/tb.sv -----
// Top of the sprite decoder testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb;

	localparam int TAIL_WAIT   = 200;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	int         mismatches;
	int         pending;
	logic [8:0] frame_bytes[$];
	int         burst_left = 0;
	int         sent = 0;
	int         idle_cycles = 0;
	int         rx_left = 0;
	int         rx_mode = 0;

	column_rle_sprite_decoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	crsd_decode_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_data     (s_axis_tdata),
		.s_last     (s_axis_tlast),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_data     (m_axis_tdata),
		.m_user     (m_axis_tuser),
		.m_last     (m_axis_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(4, 40);
		end
		rx_left--;
		case (rx_mode)
		0: m_axis_tready <= 1'b1;
		1: m_axis_tready <= ($urandom_range(0, 1) == 1);
		2: m_axis_tready <= ($urandom_range(0, 3) == 0);
		default: m_axis_tready <= ((rx_left % 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
			                                         : $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic send_frame();
		int k;
		for (k = 0; k < frame_bytes.size(); k++)
			push_byte(frame_bytes[k][7:0], frame_bytes[k][8]);
	endtask

	// hold the input off until every result is out and the decoder has settled
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
	endtask

	task automatic set_frame_size(input logic [7:0] w, input logic [7:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= crsd_pkg::REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= crsd_pkg::REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic build_frame();
		int         sel;
		int         groups;
		int         g;
		int         n;
		int         k;
		int         r;
		int         cut;
		logic [7:0] t;
		logic [7:0] bt;
		frame_bytes.delete();
		sel = $urandom_range(0, 19);
		if (sel == 0) begin
			n = $urandom_range(1, 12);
			for (k = 0; k < n; k++)
				frame_bytes.push_back({($urandom_range(0, 7) == 0),
				                       8'($urandom_range(0, 255))});
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				t = 8'($urandom_range(0, 255));
				bt = 8'($urandom_range(0, 255));
			end else begin
				t = 8'($urandom_range(0, 40));
				bt = t + 8'($urandom_range(1, 60));
			end
			frame_bytes.push_back({1'b0, t});
			frame_bytes.push_back({1'b0, bt});
			if ($urandom_range(0, 3) == 0)
				frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
			else
				frame_bytes.push_back({1'b0, 8'($urandom_range(0, 40))});
			frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
			groups = $urandom_range(1, 10);
			for (g = 0; g < groups; g++) begin
				if ($urandom_range(0, 1) == 1) begin
					n = ($urandom_range(0, 29) == 0) ? $urandom_range(7, 127)
					                                 : $urandom_range(0, 6);
					frame_bytes.push_back({1'b0, crsd_pkg::LITERAL_BIT | n[7:0]});
					for (k = 0; k < n; k++)
						frame_bytes.push_back({1'b0, 8'($urandom_range(0, 255))});
				end else begin
					r = $urandom_range(0, 19);
					if (r < 2)
						n = 0;
					else if (r == 2)
						n = $urandom_range(21, 127);
					else
						n = $urandom_range(1, 20);
					frame_bytes.push_back({1'b0, n[7:0]});
				end
			end
			// cut some frames short at a random byte, which can end them mid-header or mid-literal
			if (sel <= 3) begin
				cut = $urandom_range(0, frame_bytes.size() - 1);
				while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
			end
		end
		frame_bytes[frame_bytes.size() - 1][8] = 1'b1;
	endtask

	initial begin
		int         ph;
		logic [7:0] w;
		logic [7:0] h;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'h00;
		s_axis_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= crsd_pkg::REG_FRAME_WIDTH;
		cfg_data <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		frame_bytes = '{9'h000, 9'h040, 9'h000, 9'h0ff, 9'h082, 9'h000, 9'h0ff,
		                9'h000, 9'h080, 9'h07f, 9'h101,
		                9'h009, 9'h003, 9'h0fa, 9'h000, 9'h07f, 9'h07f, 9'h081, 9'h15a,
		                9'h001, 9'h102,
		                9'h000, 9'h004, 9'h000, 9'h000, 9'h001, 9'h183};
		send_frame();
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph)
			0: begin w = 8'd1; h = 8'd1; end
			1: begin w = 8'd255; h = 8'd255; end
			2: begin w = 8'd1; h = 8'd255; end
			3: begin w = 8'd255; h = 8'd1; end
			default: begin
				w = 8'($urandom_range(1, 255));
				h = 8'($urandom_range(1, 255));
			end
			endcase
			set_frame_size(w, h);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_frame();
				send_frame();
			end
			drain();
		end

		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
